// ----- sv/qdc_pkg.sv -----
// Shared constants for the dual quadrature counter: result width,
// configuration register indexes and pin bit positions. No dependencies.
package qdc_pkg;

  // Width of every result field on the output channel
  localparam int OUT_WIDTH = 32;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_FIRST  = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INVERT_SECOND = 1'b1;

  // Bit positions inside the packed pin sample
  localparam int PIN_FIRST_A  = 0;
  localparam int PIN_FIRST_B  = 1;
  localparam int PIN_SECOND_A = 2;
  localparam int PIN_SECOND_B = 3;
  localparam int PIN_COUNT    = 4;

endpackage

// ----- sv/qdc_if.sv -----
// Channel interfaces of the dual quadrature counter: pin sample input beat
// and position/rate result beat. Depends on qdc_pkg.
interface qdc_in_if;
  logic valid;
  logic ready;
  logic first_a;
  logic first_b;
  logic second_a;
  logic second_b;
  logic sample_tick;
  logic clear_counts;

  modport source (output valid, first_a, first_b, second_a, second_b,
                  sample_tick, clear_counts, input ready);
  modport sink (input valid, first_a, first_b, second_a, second_b,
                sample_tick, clear_counts, output ready);
endinterface

interface qdc_out_if import qdc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] first_position;
  logic signed [OUT_WIDTH-1:0] second_position;
  logic signed [OUT_WIDTH-1:0] first_rate;
  logic signed [OUT_WIDTH-1:0] second_rate;

  modport source (output valid, first_position, second_position, first_rate,
                  second_rate, input ready);
  modport sink (input valid, first_position, second_position, first_rate,
                second_rate, output ready);
endinterface

// ----- sv/dual_quadrature_counter_with_speed.sv -----
// Top level of the dual quadrature counter with per-tick speed.
// Depends on qdc_pkg and the channel interfaces in qdc_if.sv.
//
// Usage:
//   pins carries one beat per pin sample of two quadrature encoders (A/B
//   levels), a sample tick and a clear flag. Each accepted beat yields
//   exactly one beat on result: both counts and both speeds after the
//   encoders' polarity settings, 32-bit two's complement.
//   Rising-edge 2x decoding: a pin rise counts one step, direction set by
//   the level of the other phase; encoder two counts in the opposite sense.
//   A tick latches speed as the count change since the previous tick; the
//   first tick after reset only latches the counts.
//   The result of a beat is presented the cycle after acceptance.
//   Throughput: one beat per cycle when not stalled; the state update is
//   one adder stage for the count and one subtractor for the speed, both in that cycle.
//   The count and speed registers double as the result register, so a new
//   beat is taken whenever the result register is empty or being taken.
//   Stall: while result is held, pins.ready stays low and the state holds.
//   Reset clears counts, speeds, pin history and polarity, and arms the
//   first-tick flag. Write cfg_* only while the block is idle.
module dual_quadrature_counter_with_speed import qdc_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  qdc_in_if.sink                     pins,
  qdc_out_if.source                  result,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic                       cfg_data
);

  logic                   invert_first;
  logic                   invert_second;
  logic [PIN_COUNT-1:0]   previous_pins;
  logic [COUNT_WIDTH-1:0] count_one;
  logic [COUNT_WIDTH-1:0] count_two;
  logic [COUNT_WIDTH-1:0] last_sampled_one;
  logic [COUNT_WIDTH-1:0] last_sampled_two;
  logic [COUNT_WIDTH-1:0] rate_one;
  logic [COUNT_WIDTH-1:0] rate_two;
  logic                   awaiting_first_tick;
  logic                   out_valid;

  logic                   accept;
  logic [PIN_COUNT-1:0]   pins_now;
  logic [PIN_COUNT-1:0]   rise;
  logic signed [2:0]      step_one;
  logic signed [2:0]      step_two;
  logic [COUNT_WIDTH-1:0] base_one;
  logic [COUNT_WIDTH-1:0] base_two;
  logic [COUNT_WIDTH-1:0] count_one_next;
  logic [COUNT_WIDTH-1:0] count_two_next;

  // Take a beat when the result register is empty or drains this cycle
  assign pins.ready = !out_valid || result.ready;
  assign accept     = pins.valid && pins.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_first  <= 1'b0;
      invert_second <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INVERT_FIRST:  invert_first  <= cfg_data;
        REG_INVERT_SECOND: invert_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Detect rising pin edges against the previous sample
  always_comb begin
    pins_now = '0;
    pins_now[PIN_FIRST_A]  = pins.first_a;
    pins_now[PIN_FIRST_B]  = pins.first_b;
    pins_now[PIN_SECOND_A] = pins.second_a;
    pins_now[PIN_SECOND_B] = pins.second_b;
    rise = pins_now & ~previous_pins;
  end

  // Combine both edges of each encoder into one signed step
  always_comb begin
    step_one = 3'sd0;
    step_two = 3'sd0;
    if (rise[PIN_FIRST_A]) begin
      step_one = pins.first_b ? -3'sd1 : 3'sd1;
    end
    if (rise[PIN_FIRST_B]) begin
      step_one = step_one + (pins.first_a ? 3'sd1 : -3'sd1);
    end
    if (rise[PIN_SECOND_A]) begin
      step_two = pins.second_b ? 3'sd1 : -3'sd1;
    end
    if (rise[PIN_SECOND_B]) begin
      step_two = step_two + (pins.second_a ? -3'sd1 : 3'sd1);
    end
  end

  // Clear first, then apply the step
  assign base_one       = pins.clear_counts ? '0 : count_one;
  assign base_two       = pins.clear_counts ? '0 : count_two;
  assign count_one_next = base_one + COUNT_WIDTH'(step_one);
  assign count_two_next = base_two + COUNT_WIDTH'(step_two);

  // Advance counts, tick history and the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pins       <= '0;
      count_one           <= '0;
      count_two           <= '0;
      last_sampled_one    <= '0;
      last_sampled_two    <= '0;
      rate_one            <= '0;
      rate_two            <= '0;
      awaiting_first_tick <= 1'b1;
      out_valid           <= 1'b0;
    end else begin
      if (accept) begin
        previous_pins <= pins_now;
        count_one     <= count_one_next;
        count_two     <= count_two_next;
        if (pins.sample_tick) begin
          if (!awaiting_first_tick) begin
            rate_one <= count_one_next - last_sampled_one;
            rate_two <= count_two_next - last_sampled_two;
          end
          awaiting_first_tick <= 1'b0;
          last_sampled_one    <= count_one_next;
          last_sampled_two    <= count_two_next;
        end
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sign-extend or truncate to the result width, then apply polarity
  logic signed [63:0] ext_count_one;
  logic signed [63:0] ext_count_two;
  logic signed [63:0] ext_rate_one;
  logic signed [63:0] ext_rate_two;

  assign ext_count_one = 64'(signed'(count_one));
  assign ext_count_two = 64'(signed'(count_two));
  assign ext_rate_one  = 64'(signed'(rate_one));
  assign ext_rate_two  = 64'(signed'(rate_two));

  assign result.valid = out_valid;
  assign result.first_position = invert_first ? -ext_count_one[OUT_WIDTH-1:0]
                                              : ext_count_one[OUT_WIDTH-1:0];
  assign result.second_position = invert_second ? -ext_count_two[OUT_WIDTH-1:0]
                                                : ext_count_two[OUT_WIDTH-1:0];
  assign result.first_rate = invert_first ? -ext_rate_one[OUT_WIDTH-1:0]
                                          : ext_rate_one[OUT_WIDTH-1:0];
  assign result.second_rate = invert_second ? -ext_rate_two[OUT_WIDTH-1:0]
                                            : ext_rate_two[OUT_WIDTH-1:0];

`ifndef SYNTHESIS
  // An accepted beat always produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // Speeds move only on an accepted tick
  a_rate_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(accept && pins.sample_tick) |=> $stable(rate_one) && $stable(rate_two))
    else $error("speed changed without a tick");

  // First-tick flag clears only on an accepted tick and never rearms
  a_first_tick_flag: assert property (@(posedge clk) disable iff (rst)
    !awaiting_first_tick |=> !awaiting_first_tick)
    else $error("first-tick flag rearmed");

  // A clear with no rising edge leaves both counts at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (accept && pins.clear_counts && (rise == '0)) |=>
      (count_one == '0) && (count_two == '0))
    else $error("clear did not zero the counts");

  // State holds while no beat is accepted
  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count_one) && $stable(count_two) && $stable(previous_pins))
    else $error("state changed without an accepted beat");
`endif

endmodule
